// ===== sv/hotp_pkg.sv =====
// Package: shared types, constants and helper function of the one-time code generator.
`default_nettype none
package hotp_pkg;
    localparam int KEY_BYTES = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CODE_W = 30;
    localparam int CTR_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS = 2'd3;

    localparam logic [3:0] DIGITS_RESET = 4'd6;
    localparam logic [3:0] DIGITS_MAX = 4'd9;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // Block selectors for the four compressions.
    typedef enum logic [1:0] {
        t_blk_ipad  = 2'd0,
        t_blk_imsg  = 2'd1,
        t_blk_opad  = 2'd2,
        t_blk_omsg  = 2'd3
    } t_blk;

    typedef enum logic [2:0] {
        t_st_idle   = 3'd0,
        t_st_load   = 3'd1,
        t_st_round  = 3'd2,
        t_st_fold   = 3'd3,
        t_st_trunc  = 3'd4,
        t_st_mod    = 3'd5,
        t_st_out    = 3'd6
    } t_state;

    typedef struct packed {
        logic       start;     // capture counter, init hash
        logic       load;      // load message block
        t_blk       blk;
        logic       round;     // run one round
        logic       fold;      // add working vars into hash
        logic       trunc;     // dynamic truncation
        logic       mod_step;  // one restoring-subtract step
        logic       mod_init;
    } t_cmd;

    typedef struct packed {
        logic last_round;
        logic mod_done;
    } t_sts;

    function automatic logic [31:0] pow10(input logic [3:0] d);
        logic [31:0] r;
        case (d)
            4'd0: r = 32'd1;
            4'd1: r = 32'd10;
            4'd2: r = 32'd100;
            4'd3: r = 32'd1000;
            4'd4: r = 32'd10000;
            4'd5: r = 32'd100000;
            4'd6: r = 32'd1000000;
            4'd7: r = 32'd10000000;
            4'd8: r = 32'd100000000;
            default: r = 32'd1000000000;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== sv/hotp_if.sv =====
// Interfaces: valid/ready channels for counter requests and code results.
`default_nettype none
interface hotp_ctr_if import hotp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CTR_W-1:0] counter;
    modport source (output valid, output counter, input ready);
    modport sink   (input valid, input counter, output ready);
endinterface

interface hotp_code_if import hotp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;
    modport source (output valid, output code, input ready);
    modport sink   (input valid, input code, output ready);
endinterface
`default_nettype wire

// ===== sv/hotp_dp.sv =====
// Datapath: SHA-1 round engine, message schedule, truncation and modulo unit.
`default_nettype none
module hotp_dp import hotp_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic [CTR_W-1:0] i_counter,
    input  wire logic [63:0]      i_key0,
    input  wire logic [63:0]      i_key1,
    input  wire logic [31:0]      i_key2,
    input  wire logic [3:0]       i_digits,
    output logic [CODE_W-1:0]     o_code
);
    logic [31:0] r_h [5];
    logic [31:0] r_ih [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic [CTR_W-1:0] r_ctr;
    logic [31:0] r_rem;
    logic [62:0] r_div;
    logic [4:0]  r_mcnt;

    logic [7:0]  key_b [KEY_BYTES];
    logic [31:0] blk_w [16];
    logic [31:0] f, k, t, w_new, wi;
    logic [159:0] dig;
    logic [3:0]  off;
    logic [31:0] word;
    logic [3:0]  dsat;
    logic [63:0] sub;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            key_b[i]   = i_key0[63-8*i -: 8];
            key_b[8+i] = i_key1[63-8*i -: 8];
        end
        for (int i = 0; i < 4; i++) begin
            key_b[16+i] = i_key2[31-8*i -: 8];
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            blk_w[i] = 32'd0;
        end
        case (i_cmd.blk)
            t_blk_ipad, t_blk_opad: begin
                for (int i = 0; i < 16; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        if (i*4+j < KEY_BYTES) begin
                            blk_w[i][31-8*j -: 8] = key_b[i*4+j]
                                ^ ((i_cmd.blk == t_blk_ipad) ? 8'h36 : 8'h5C);
                        end else begin
                            blk_w[i][31-8*j -: 8] =
                                (i_cmd.blk == t_blk_ipad) ? 8'h36 : 8'h5C;
                        end
                    end
                end
            end
            t_blk_imsg: begin
                blk_w[0]  = r_ctr[63:32];
                blk_w[1]  = r_ctr[31:0];
                blk_w[2]  = 32'h80000000;
                blk_w[15] = 32'd576;
            end
            default: begin
                for (int i = 0; i < 5; i++) begin
                    blk_w[i] = r_ih[i];
                end
                blk_w[5]  = 32'h80000000;
                blk_w[15] = 32'd672;
            end
        endcase
    end

    always_comb begin
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = 32'h5A827999;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = 32'h6ED9EBA1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = 32'h8F1BBCDC;
        end else begin
            f = r_b ^ r_c ^ r_d; k = 32'hCA62C1D6;
        end
        wi = r_w[0];
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + wi;
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_comb begin
        dig = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
        off = dig[3:0];
        word = dig[159 - 8*off -: 32];
        word[31] = 1'b0;
        dsat = (i_digits > DIGITS_MAX) ? DIGITS_MAX : i_digits;
        sub = {32'd0, r_rem} - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ctr <= i_counter;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end
        if (i_cmd.load) begin
            r_w <= blk_w;
            r_rnd <= 7'd0;
            if (i_cmd.blk == t_blk_opad) begin
                r_ih <= r_h;
                r_a <= H0; r_b <= H1; r_c <= H2; r_d <= H3; r_e <= H4;
            end else begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                r_d <= r_h[3]; r_e <= r_h[4];
            end
            if (i_cmd.blk == t_blk_opad) begin
                r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
            end
        end
        if (i_cmd.round) begin
            r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a; r_a <= t;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_rnd <= r_rnd + 7'd1;
        end
        if (i_cmd.fold) begin
            r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b; r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d; r_h[4] <= r_h[4] + r_e;
        end
        if (i_cmd.trunc) begin
            r_rem <= word;
        end
        if (i_cmd.mod_init) begin
            r_div <= {pow10(dsat), 31'd0};
            r_mcnt <= 5'd0;
        end
        if (i_cmd.mod_step) begin
            // restoring reduction by shifted modulus, largest first
            if (!sub[63]) begin
                r_rem <= sub[31:0];
            end
            r_div <= r_div >> 1;
            r_mcnt <= r_mcnt + 5'd1;
        end
    end

    // Shifted multiples of 10^d: compare from 2^k*m downward.
    assign o_sts.last_round = (r_rnd == 7'd79);
    assign o_sts.mod_done   = (r_mcnt == 5'd31);
    assign o_code = r_rem[CODE_W-1:0];
endmodule
`default_nettype wire

// ===== sv/hotp_ctrl.sv =====
// Controller: sequences the four compressions, truncation and modulo.
`default_nettype none
module hotp_ctrl import hotp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    t_blk   r_blk, n_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_st_idle;
            r_blk <= t_blk_ipad;
        end else begin
            r_state <= n_state;
            r_blk <= n_blk;
        end
    end

    always_comb begin
        n_state = r_state;
        n_blk = r_blk;
        case (r_state)
            t_st_idle: if (i_in_valid) begin
                n_state = t_st_load; n_blk = t_blk_ipad;
            end
            t_st_load: n_state = t_st_round;
            t_st_round: if (i_sts.last_round) n_state = t_st_fold;
            t_st_fold: begin
                if (r_blk == t_blk_omsg) begin
                    n_state = t_st_trunc;
                end else begin
                    n_state = t_st_load;
                    n_blk = t_blk'(r_blk + 2'd1);
                end
            end
            t_st_trunc: n_state = t_st_mod;
            t_st_mod: if (i_sts.mod_done) n_state = t_st_out;
            t_st_out: if (i_out_ready) n_state = t_st_idle;
            default: n_state = t_st_idle;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.blk = r_blk;
        o_in_ready = (r_state == t_st_idle);
        o_out_valid = (r_state == t_st_out);
        case (r_state)
            t_st_idle:  o_cmd.start = i_in_valid;
            t_st_load:  o_cmd.load = 1'b1;
            t_st_round: o_cmd.round = 1'b1;
            t_st_fold:  o_cmd.fold = 1'b1;
            t_st_trunc: begin
                o_cmd.trunc = 1'b1;
                o_cmd.mod_init = 1'b1;
            end
            t_st_mod:   o_cmd.mod_step = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/hmac_sha1_otp_generator.sv =====
// Top level: HMAC-SHA1 one-time code generator with configuration port.
// A request is processed from acceptance to result by four SHA-1
// compressions of 80 rounds each on one round engine, each with a load and
// a fold step, then truncation and a 32-step modulo reduction, and the next
// request is taken at the edge after the result has been delivered. The
// 31-bit truncated value is reduced by compare-subtract against the modulus
// shifted left by 31 down to 0. Registers:
// 0..2 key bytes, 3 digit count (above nine acts as nine). Unknown indices
// are ignored.
`default_nettype none
module hmac_sha1_otp_generator import hotp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    hotp_ctr_if.sink                   s_in,
    hotp_code_if.source                m_out
);
    logic [63:0] r_key0, r_key1;
    logic [31:0] r_key2;
    logic [3:0]  r_digits;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0;
            r_digits <= DIGITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0:   r_key0 <= i_cfg_data;
                REG_KEY1:   r_key1 <= i_cfg_data;
                REG_KEY2:   r_key2 <= i_cfg_data[31:0];
                REG_DIGITS: r_digits <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    hotp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    hotp_dp u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .o_sts(sts),
        .i_counter(s_in.counter),
        .i_key0(r_key0), .i_key1(r_key1), .i_key2(r_key2),
        .i_digits(r_digits), .o_code(m_out.code)
    );
endmodule
`default_nettype wire

// ===== sv/hotp_chk.sv =====
// Checker: port-level properties of the one-time code generator, with bind.
`default_nettype none
module hotp_chk import hotp_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CODE_W-1:0] code
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("busy overlap");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code)) else $error("result dropped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> code < 30'd1000000000) else $error("code range");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule

bind hmac_sha1_otp_generator hotp_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .code(m_out.code)
);
`default_nettype wire
